// ----- rtl/swat_pkg.sv -----
// Shared types, codes and reset values for the sliding-window ack tracker.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package swat_pkg;

   // Default number of window slots.
   localparam int unsigned WINDOW_MAX_DEFAULT = 32;

   // Fixed field widths.
   localparam int unsigned SEQ_W    = 16;
   localparam int unsigned WSIZE_W  = 6;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned LIMIT_W  = 4;
   localparam int unsigned SLIDE_W  = 6;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_SLOTS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd2;

   // Configuration reset values.
   localparam logic [WSIZE_W-1:0] WIN_SLOTS_RESET     = 6'd4;
   localparam logic [COUNT_W-1:0] CHUNK_COUNT_RESET   = 16'd1;
   localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RESET = 4'd3;

   // Saturation points of the counters.
   localparam logic [COUNT_W-1:0] ACKS_MAX    = 16'hFFFF;
   localparam logic [LIMIT_W-1:0] TIMEOUT_MAX = 4'hF;

   // Event kinds carried in the func field.
   localparam logic FUNC_ACK     = 1'b0;
   localparam logic FUNC_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_RUNNING = 2'd0,
      STATUS_DONE    = 2'd1,
      STATUS_ABORTED = 2'd2
   } status_type;

   // Per-cell control, driven by the top level for every slot cell.
   typedef struct packed {
      logic load;       // an in-window ack is being applied this cycle
      logic in_window;  // this slot lies below the effective window size
      logic set_hit;    // the incoming ack lands on this slot
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/swat_if.sv -----
// Valid/ready channel interfaces for the ack tracker's event and result streams.
// Depends on swat_pkg for field widths.
`default_nettype none

interface swat_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [swat_pkg::SEQ_W-1:0]  ack_seq;

   modport source (output valid, output func, output ack_seq, input ready);
   modport sink   (input valid, input func, input ack_seq, output ready);
endinterface

interface swat_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [swat_pkg::SEQ_W-1:0]    window_first;
   logic [swat_pkg::SEQ_W-1:0]    window_last;
   logic [swat_pkg::SLIDE_W-1:0]  slide_amount;
   logic                          ack_rejected;
   logic [1:0]                    run_status;

   modport source (output valid, output window_first, output window_last,
                   output slide_amount, output ack_rejected, output run_status,
                   input ready);
   modport sink   (input valid, input window_first, input window_last,
                   input slide_amount, input ack_rejected, input run_status,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/sliding_window_ack_tracker.sv -----
// Sender-side sliding window tracker for a selective-repeat transfer. Each
// request transaction is an ack carrying a sequence number or a receive
// timeout; each one yields exactly one response transaction with the window
// range to (re)send, how far the window slid, whether the ack was rejected as
// outside the window, and the run status. The block accepts one request per
// clock unless an untaken response holds the output register, from which the
// response is presented in the cycle after acceptance; a new request is taken
// in the same cycle that the pending response is taken. The combinational path
// runs through the slot cells: the leading-acked carry ripples up from slot 0,
// and the slide count then shifts the slot bits. Once the transfer completes or
// aborts, the state freezes until reset. The user writes configuration via the
// csr_ port while the block is idle (not enforced); no clearing pass after reset.
`default_nettype none

module sliding_window_ack_tracker #(
   parameter int unsigned WINDOW_MAX = swat_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   swat_req_if.sink                                req_bus,
   swat_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [swat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [swat_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // CW holds a slot count up to WINDOW_MAX; IW indexes a slot; EW is wide
   // enough for both the slot-count register and a slot count.
   localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
   localparam int unsigned IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned EW = (CW > swat_pkg::WSIZE_W) ? CW : swat_pkg::WSIZE_W;
   localparam int unsigned SW = swat_pkg::SEQ_W;

   // Configuration registers.
   logic [swat_pkg::WSIZE_W-1:0] win_slots_ff;
   logic [swat_pkg::COUNT_W-1:0] chunk_count_ff;
   logic [swat_pkg::LIMIT_W-1:0] timeout_limit_ff;

   // Tracker state outside the slot cells.
   logic [SW-1:0]                base_ff, base_in;
   logic [swat_pkg::COUNT_W-1:0] acks_ff, acks_in;
   logic [swat_pkg::LIMIT_W-1:0] tmo_run_ff, tmo_run_in;
   swat_pkg::status_type         finished_ff, finished_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                rsp_first_ff, rsp_last_ff;
   logic [swat_pkg::SLIDE_W-1:0] rsp_slide_ff;
   logic                         rsp_rejected_ff;
   swat_pkg::status_type         rsp_status_ff;

   logic                 accept;
   logic                 running;
   logic                 is_ack;
   logic [EW-1:0]        wsize_ext;
   logic [EW-1:0]        weff_ext;
   logic [CW-1:0]        w_eff;
   logic [SW-1:0]        offset;
   logic                 hit;
   logic                 apply_ack;
   logic                 rejected;

   swat_pkg::cell_ctl_type ctl [WINDOW_MAX];
   logic [WINDOW_MAX:0]    carry;
   logic [WINDOW_MAX-1:0]  masked;
   logic [WINDOW_MAX-1:0]  first_gap;
   logic [WINDOW_MAX-1:0]  shifted;
   logic [CW-1:0]          slide;
   logic [CW-1:0]          slide_applied;

   // Handshake: the output register frees up when its response is taken.
   assign req_bus.ready = ~rsp_valid_ff | rsp_bus.ready;
   assign accept        = req_bus.valid & req_bus.ready;

   assign running = (finished_ff == swat_pkg::STATUS_RUNNING);
   assign is_ack  = (req_bus.func == swat_pkg::FUNC_ACK);

   // Effective window: zero acts as one, anything above WINDOW_MAX is capped.
   assign wsize_ext = EW'(win_slots_ff);
   always_comb begin
      weff_ext = wsize_ext;
      if (wsize_ext == '0) begin
         weff_ext = EW'(1);
      end else if (wsize_ext > EW'(WINDOW_MAX)) begin
         weff_ext = EW'(WINDOW_MAX);
      end
   end
   assign w_eff = weff_ext[CW-1:0];

   // Slot offset of the ack relative to the slot after window_base.
   assign offset    = req_bus.ack_seq - base_ff - SW'(1);
   assign hit       = (offset < SW'(w_eff));
   assign apply_ack = accept & running & is_ack & hit;
   assign rejected  = running & is_ack & ~hit;

   // The row of slot cells. Slot 0 starts the leading-acked carry.
   assign carry[0] = 1'b1;
   assign shifted  = masked >> slide;

   for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
      always_comb begin
         ctl[g].load      = apply_ack;
         ctl[g].in_window = (CW'(g) < w_eff);
         ctl[g].set_hit   = hit & is_ack & (offset[IW-1:0] == IW'(g));
      end

      swat_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[g]),
         .carry_in  (carry[g]),
         .shift_bit (shifted[g]),
         .masked    (masked[g]),
         .carry_out (carry[g+1]),
         .first_gap (first_gap[g])
      );
   end

   // The slide is the position of the first unacknowledged slot; when every
   // slot of the row is acknowledged the window moves by the whole row.
   always_comb begin
      slide = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (first_gap[i]) begin
            slide = slide | CW'(i);
         end
      end
      if (carry[WINDOW_MAX]) begin
         slide = CW'(WINDOW_MAX);
      end
   end

   assign slide_applied = apply_ack ? slide : '0;

   // Next values of the counters and of the run status.
   always_comb begin
      logic [swat_pkg::LIMIT_W-1:0] lim;
      logic [swat_pkg::COUNT_W-1:0] need;

      lim         = (timeout_limit_ff == '0) ? swat_pkg::LIMIT_W'(1) : timeout_limit_ff;
      need        = (chunk_count_ff == '0) ? swat_pkg::COUNT_W'(1) : chunk_count_ff;
      base_in     = base_ff;
      acks_in     = acks_ff;
      tmo_run_in  = tmo_run_ff;
      finished_in = finished_ff;

      if (accept && running) begin
         if (!is_ack) begin
            if (tmo_run_ff != swat_pkg::TIMEOUT_MAX) begin
               tmo_run_in = tmo_run_ff + swat_pkg::LIMIT_W'(1);
            end
            if (tmo_run_in >= lim) begin
               finished_in = swat_pkg::STATUS_ABORTED;
            end
         end else if (hit) begin
            tmo_run_in = '0;
            if (acks_ff != swat_pkg::ACKS_MAX) begin
               acks_in = acks_ff + swat_pkg::COUNT_W'(1);
            end
            base_in = base_ff + SW'(slide);
            if (acks_in >= need) begin
               finished_in = swat_pkg::STATUS_DONE;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_slots_ff     <= swat_pkg::WIN_SLOTS_RESET;
         chunk_count_ff   <= swat_pkg::CHUNK_COUNT_RESET;
         timeout_limit_ff <= swat_pkg::TIMEOUT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            swat_pkg::CSR_WIN_SLOTS: begin
               win_slots_ff <= csr_wdata[swat_pkg::WSIZE_W-1:0];
            end
            swat_pkg::CSR_CHUNK_COUNT: begin
               chunk_count_ff <= csr_wdata[swat_pkg::COUNT_W-1:0];
            end
            swat_pkg::CSR_TIMEOUT_LIMIT: begin
               timeout_limit_ff <= csr_wdata[swat_pkg::LIMIT_W-1:0];
            end
            default: begin
               // Writes to indexes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         acks_ff      <= '0;
         tmo_run_ff   <= '0;
         finished_ff  <= swat_pkg::STATUS_RUNNING;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         acks_ff      <= acks_in;
         tmo_run_ff   <= tmo_run_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload is loaded with each accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_first_ff    <= base_in;
         rsp_last_ff     <= base_in + SW'(w_eff) - SW'(1);
         rsp_slide_ff    <= swat_pkg::SLIDE_W'(slide_applied);
         rsp_rejected_ff <= rejected;
         rsp_status_ff   <= finished_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.window_first = rsp_first_ff;
   assign rsp_bus.window_last  = rsp_last_ff;
   assign rsp_bus.slide_amount = rsp_slide_ff;
   assign rsp_bus.ack_rejected = rsp_rejected_ff;
   assign rsp_bus.run_status   = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // A completed or aborted transfer never changes status until reset.
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff != swat_pkg::STATUS_RUNNING |=> finished_ff == $past(finished_ff))
      else $error("run status changed after the transfer finished");

   // The reported window never spans more than WINDOW_MAX slots.
   a_window_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff - rsp_first_ff) < SW'(WINDOW_MAX))
      else $error("reported window wider than the slot row");

   // A rejected ack neither slides the window nor moves its base.
   a_reject_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rejected_ff |-> rsp_slide_ff == '0 && base_ff == $past(base_ff))
      else $error("rejected ack moved the window");
`endif

endmodule

`default_nettype wire

// ----- rtl/swat_cell.sv -----
// One window slot: holds the acknowledged bit and passes the leading-ones
// carry to the next slot. Depends on swat_pkg for the control struct.
`default_nettype none

module swat_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire swat_pkg::cell_ctl_type ctl,
   input  wire logic                  carry_in,
   input  wire logic                  shift_bit,
   output logic                       masked,
   output logic                       carry_out,
   output logic                       first_gap
);

   logic slot_ff;
   logic slot_in;

   // Slot content as seen by this event: stale bits above the window read as
   // zero, and the incoming ack is merged in.
   assign masked    = (slot_ff & ctl.in_window) | ctl.set_hit;
   assign carry_out = carry_in & masked;
   assign first_gap = carry_in & ~masked;

   assign slot_in = ctl.load ? shift_bit : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire
